>>> rtl/core/ppu_pkg.sv
// ----------------------------------------------------------------------------
// ppu_pkg
// shared constants, types and the palette for the palette pixel upscaler
// ----------------------------------------------------------------------------
package ppu_pkg;

    // frame geometry
    localparam int SRC_WIDTH    = 320;
    localparam int SRC_HEIGHT   = 200;
    localparam int PANEL_WIDTH  = 640;
    localparam int PANEL_HEIGHT = 480;
    localparam int MAX_SCALE    = 8;

    // field widths
    localparam int COORD_W  = 11;
    localparam int PIX_W    = 10;
    localparam int COLOR_W  = 8;
    localparam int SCALE_W  = 4;
    localparam int OFFS_W   = 10;
    localparam int ADDR_W   = 20;
    localparam int RGB_W    = 16;
    localparam int SIDX_W   = 16;
    localparam int SUB_W    = 3;
    localparam int POS_W    = 14;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y = 2'd2;

    // register reset values
    localparam logic [SCALE_W-1:0] SCALE_RST    = 4'd2;
    localparam logic [OFFS_W-1:0]  OFFSET_X_RST = 10'd0;
    localparam logic [OFFS_W-1:0]  OFFSET_Y_RST = 10'd40;

    // controller to datapath commands
    typedef struct packed {
        logic load;   // capture the accepted pixel
        logic mul;    // scaled position and back buffer index
        logic base;   // panel origin and clipped run size
        logic addr;   // first panel address of the run
        logic emit;   // present the next beat on the output
    } t_ppu_cmd;

    // datapath to controller status
    typedef struct packed {
        logic in_range;   // incoming pixel lies inside the source frame
        logic run_empty;  // whole run lands off the panel
        logic out_free;   // output register can take a beat
        logic emit_last;  // current run position is the last one
    } t_ppu_status;

    // 16 entry BGR565 palette
    function automatic logic [RGB_W-1:0] palette_lookup(input logic [3:0] nib);
        logic [RGB_W-1:0] c;
        case (nib)
            4'h0:    c = 16'h0000;
            4'h1:    c = 16'hA800;
            4'h2:    c = 16'h02A0;
            4'h3:    c = 16'hAAA0;
            4'h4:    c = 16'h0015;
            4'h5:    c = 16'hA815;
            4'h6:    c = 16'h0554;
            4'h7:    c = 16'hBDD7;
            4'h8:    c = 16'h8410;
            4'h9:    c = 16'hAC10;
            4'hA:    c = 16'h06B0;
            4'hB:    c = 16'hAEB0;
            4'hC:    c = 16'h001F;
            4'hD:    c = 16'hA81F;
            4'hE:    c = 16'h055E;
            default: c = 16'hFFFF;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/core/ppu_ctrl.sv
// ----------------------------------------------------------------------------
// ppu_ctrl
// sequencer: accept, three setup steps, then one panel beat per free slot
// ----------------------------------------------------------------------------
module ppu_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  ppu_pkg::t_ppu_status i_status,
    output ppu_pkg::t_ppu_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_BASE = 3'd2;
    localparam logic [2:0] S_ADDR = 3'd3;
    localparam logic [2:0] S_RUN  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       accept;

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = accept;
                if (accept && i_status.in_range) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_BASE;
            end
            S_BASE: begin
                o_cmd.base = 1'b1;
                n_state    = i_status.run_empty ? S_IDLE : S_ADDR;
            end
            S_ADDR: begin
                o_cmd.addr = 1'b1;
                n_state    = S_RUN;
            end
            S_RUN: begin
                o_cmd.emit = i_status.out_free;
                if (i_status.out_free && i_status.emit_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> rtl/core/ppu_dp.sv
// ----------------------------------------------------------------------------
// ppu_dp
// datapath: config registers, scaling arithmetic, run counters, output beat
// ----------------------------------------------------------------------------
module ppu_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ppu_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ppu_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic signed [ppu_pkg::COORD_W-1:0]  i_pixel_x,
    input  logic signed [ppu_pkg::COORD_W-1:0]  i_pixel_y,
    input  logic [ppu_pkg::COLOR_W-1:0]         i_color_index,
    input  logic                                i_stall,
    input  ppu_pkg::t_ppu_cmd                   i_cmd,
    output ppu_pkg::t_ppu_status                o_status,
    output logic                                o_valid,
    output logic [ppu_pkg::ADDR_W-1:0]          o_panel_address,
    output logic [ppu_pkg::RGB_W-1:0]           o_panel_color,
    output logic                                o_run_last,
    output logic                                o_shadow_write,
    output logic [ppu_pkg::SIDX_W-1:0]          o_shadow_index,
    output logic [ppu_pkg::COLOR_W-1:0]         o_shadow_color
);

    // configuration
    logic [ppu_pkg::SCALE_W-1:0] r_cfg_scale;
    logic [ppu_pkg::OFFS_W-1:0]  r_offset_x;
    logic [ppu_pkg::OFFS_W-1:0]  r_offset_y;

    // captured pixel
    logic [ppu_pkg::PIX_W-1:0]   r_px;
    logic [ppu_pkg::PIX_W-1:0]   r_py;
    logic [ppu_pkg::COLOR_W-1:0] r_cbyte;
    logic [ppu_pkg::SCALE_W-1:0] r_scale;
    logic [ppu_pkg::RGB_W-1:0]   r_run_color;

    // setup results
    logic [ppu_pkg::POS_W-1:0]   r_px_s;
    logic [ppu_pkg::POS_W-1:0]   r_py_s;
    logic [ppu_pkg::SIDX_W-1:0]  r_sidx;
    logic [ppu_pkg::OFFS_W-1:0]  r_col0;
    logic [ppu_pkg::OFFS_W-1:0]  r_row0;
    logic [ppu_pkg::SUB_W-1:0]   r_last_col;
    logic [ppu_pkg::SUB_W-1:0]   r_last_row;

    // run state
    logic [ppu_pkg::ADDR_W-1:0]  r_row_addr;
    logic [ppu_pkg::ADDR_W-1:0]  r_addr;
    logic [ppu_pkg::SUB_W-1:0]   r_sub_col;
    logic [ppu_pkg::SUB_W-1:0]   r_sub_row;
    logic                        r_first;
    logic                        r_out_valid;

    logic [ppu_pkg::SCALE_W-1:0] scale_clamped;
    logic                        x_ok;
    logic                        y_ok;
    logic [ppu_pkg::POS_W-1:0]   col_base;
    logic [ppu_pkg::POS_W-1:0]   row_base;
    logic                        col_ok;
    logic                        row_ok;
    logic [ppu_pkg::POS_W:0]     col_rem;
    logic [ppu_pkg::POS_W:0]     row_rem;
    logic [ppu_pkg::SCALE_W-1:0] n_cols;
    logic [ppu_pkg::SCALE_W-1:0] n_rows;
    logic [ppu_pkg::PIX_W+10:0]  sidx_full;
    logic [ppu_pkg::ADDR_W-1:0]  addr0;
    logic                        at_last_col;

    // config writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_scale <= ppu_pkg::SCALE_RST;
            r_offset_x  <= ppu_pkg::OFFSET_X_RST;
            r_offset_y  <= ppu_pkg::OFFSET_Y_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ppu_pkg::CFG_SCALE:    r_cfg_scale <= i_cfg_data[ppu_pkg::SCALE_W-1:0];
                ppu_pkg::CFG_OFFSET_X: r_offset_x  <= i_cfg_data[ppu_pkg::OFFS_W-1:0];
                ppu_pkg::CFG_OFFSET_Y: r_offset_y  <= i_cfg_data[ppu_pkg::OFFS_W-1:0];
                default: ;
            endcase
        end
    end

    // scale saturated to 1..MAX_SCALE
    always_comb begin
        if (r_cfg_scale == '0) begin
            scale_clamped = ppu_pkg::SCALE_W'(1);
        end else if (r_cfg_scale > ppu_pkg::SCALE_W'(ppu_pkg::MAX_SCALE)) begin
            scale_clamped = ppu_pkg::SCALE_W'(ppu_pkg::MAX_SCALE);
        end else begin
            scale_clamped = r_cfg_scale;
        end
    end

    // source frame check on the incoming pixel
    assign x_ok = !i_pixel_x[ppu_pkg::COORD_W-1] &&
                  ($unsigned(i_pixel_x) < ppu_pkg::COORD_W'(ppu_pkg::SRC_WIDTH));
    assign y_ok = !i_pixel_y[ppu_pkg::COORD_W-1] &&
                  ($unsigned(i_pixel_y) < ppu_pkg::COORD_W'(ppu_pkg::SRC_HEIGHT));

    // capture stage
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px        <= i_pixel_x[ppu_pkg::PIX_W-1:0];
            r_py        <= i_pixel_y[ppu_pkg::PIX_W-1:0];
            r_cbyte     <= i_color_index;
            r_scale     <= scale_clamped;
            r_run_color <= ppu_pkg::palette_lookup(i_color_index[3:0]);
        end
    end

    // scaled position and back buffer index
    assign sidx_full = (ppu_pkg::PIX_W+11)'(r_py) * (ppu_pkg::PIX_W+11)'(ppu_pkg::SRC_WIDTH)
                     + (ppu_pkg::PIX_W+11)'(r_px);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_px_s <= ppu_pkg::POS_W'(r_px) * ppu_pkg::POS_W'(r_scale);
            r_py_s <= ppu_pkg::POS_W'(r_py) * ppu_pkg::POS_W'(r_scale);
            r_sidx <= sidx_full[ppu_pkg::SIDX_W-1:0];
        end
    end

    // panel origin and clipped run extent
    assign col_base = ppu_pkg::POS_W'(r_offset_x) + r_px_s;
    assign row_base = ppu_pkg::POS_W'(r_offset_y) + r_py_s;
    assign col_ok   = col_base < ppu_pkg::POS_W'(ppu_pkg::PANEL_WIDTH);
    assign row_ok   = row_base < ppu_pkg::POS_W'(ppu_pkg::PANEL_HEIGHT);
    assign col_rem  = (ppu_pkg::POS_W+1)'(ppu_pkg::PANEL_WIDTH)  - {1'b0, col_base};
    assign row_rem  = (ppu_pkg::POS_W+1)'(ppu_pkg::PANEL_HEIGHT) - {1'b0, row_base};
    assign n_cols   = (col_rem < (ppu_pkg::POS_W+1)'(r_scale)) ?
                      col_rem[ppu_pkg::SCALE_W-1:0] : r_scale;
    assign n_rows   = (row_rem < (ppu_pkg::POS_W+1)'(r_scale)) ?
                      row_rem[ppu_pkg::SCALE_W-1:0] : r_scale;

    always_ff @(posedge i_clk) begin
        if (i_cmd.base) begin
            r_col0     <= col_base[ppu_pkg::OFFS_W-1:0];
            r_row0     <= row_base[ppu_pkg::OFFS_W-1:0];
            r_last_col <= ppu_pkg::SUB_W'(n_cols - 1'b1);
            r_last_row <= ppu_pkg::SUB_W'(n_rows - 1'b1);
        end
    end

    // first address of the run
    assign addr0 = ppu_pkg::ADDR_W'(r_row0) * ppu_pkg::ADDR_W'(ppu_pkg::PANEL_WIDTH)
                 + ppu_pkg::ADDR_W'(r_col0);

    assign at_last_col = (r_sub_col == r_last_col);

    // run walk, row-major
    always_ff @(posedge i_clk) begin
        if (i_cmd.addr) begin
            r_row_addr <= addr0;
            r_addr     <= addr0;
            r_sub_col  <= '0;
            r_sub_row  <= '0;
            r_first    <= 1'b1;
        end else if (i_cmd.emit) begin
            r_first <= 1'b0;
            if (at_last_col) begin
                r_sub_col  <= '0;
                r_sub_row  <= r_sub_row + 1'b1;
                r_row_addr <= r_row_addr + ppu_pkg::ADDR_W'(ppu_pkg::PANEL_WIDTH);
                r_addr     <= r_row_addr + ppu_pkg::ADDR_W'(ppu_pkg::PANEL_WIDTH);
            end else begin
                r_sub_col <= r_sub_col + 1'b1;
                r_addr    <= r_addr + 1'b1;
            end
        end
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_panel_address <= r_addr;
            o_panel_color   <= r_run_color;
            o_run_last      <= o_status.emit_last;
            o_shadow_write  <= r_first;
            o_shadow_index  <= r_sidx;
            o_shadow_color  <= r_cbyte;
        end
    end

    assign o_valid = r_out_valid;

    // status to the controller
    assign o_status.in_range  = x_ok && y_ok;
    assign o_status.run_empty = !(col_ok && row_ok);
    assign o_status.out_free  = !r_out_valid || !i_stall;
    assign o_status.emit_last = at_last_col && (r_sub_row == r_last_row);

endmodule

>>> rtl/core/palette_pixel_upscaler_top.sv
// ----------------------------------------------------------------------------
// palette_pixel_upscaler_top
// nearest neighbor upscaler: one source pixel becomes a clipped block of
// BGR565 panel writes, the first of which also carries the back buffer write
// ----------------------------------------------------------------------------
// the accepted pixel is captured, then multiplied, clipped and addressed before
//   its first panel beat enters the output register; the run walk then gives
//   one beat per cycle while the output is not stalled, and o_stall holds the
//   input until the last beat of the run is emitted
// pixels outside the source frame skip setup, fully clipped runs end after clip
// reset: synchronous active low; scale 2, offset_x 0, offset_y 40, idle

module palette_pixel_upscaler_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ppu_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ppu_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [ppu_pkg::COORD_W-1:0]  i_pixel_x,
    input  logic signed [ppu_pkg::COORD_W-1:0]  i_pixel_y,
    input  logic [ppu_pkg::COLOR_W-1:0]         i_color_index,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [ppu_pkg::ADDR_W-1:0]          o_panel_address,
    output logic [ppu_pkg::RGB_W-1:0]           o_panel_color,
    output logic                                o_run_last,
    output logic                                o_shadow_write,
    output logic [ppu_pkg::SIDX_W-1:0]          o_shadow_index,
    output logic [ppu_pkg::COLOR_W-1:0]         o_shadow_color
);

    ppu_pkg::t_ppu_cmd    cmd;
    ppu_pkg::t_ppu_status status;

    // sequencer
    ppu_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // arithmetic and output register
    ppu_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_pixel_x       (i_pixel_x),
        .i_pixel_y       (i_pixel_y),
        .i_color_index   (i_color_index),
        .i_stall         (i_stall),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_valid         (o_valid),
        .o_panel_address (o_panel_address),
        .o_panel_color   (o_panel_color),
        .o_run_last      (o_run_last),
        .o_shadow_write  (o_shadow_write),
        .o_shadow_index  (o_shadow_index),
        .o_shadow_color  (o_shadow_color)
    );

endmodule

>>> rtl/core/ppu_checker.sv
// ----------------------------------------------------------------------------
// ppu_checker
// port-level checks on the upscaler output stream
// ----------------------------------------------------------------------------
module ppu_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_stall,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [ppu_pkg::ADDR_W-1:0]    o_panel_address,
    input logic                          o_run_last,
    input logic                          o_shadow_write
);

    logic r_expect_first;

    // first beat of every run follows reset or a taken last beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_first <= 1'b1;
        end else if (o_valid && !i_stall) begin
            r_expect_first <= o_run_last;
        end
    end

    // stalled beat holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_panel_address)
                               && $stable(o_run_last) && $stable(o_shadow_write))
        else $error("stalled beat changed");

    // back buffer write flag only on the first beat of a run
    a_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_shadow_write == r_expect_first))
        else $error("shadow write flag out of place");

    // no new pixel taken while a run is still streaming
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_run_last |-> o_stall)
        else $error("input open during a run");

    // beats within a run follow back to back at rising addresses
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_run_last |=>
            o_valid && (o_panel_address > $past(o_panel_address)))
        else $error("run beats out of order");

endmodule

bind palette_pixel_upscaler_top ppu_checker u_ppu_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_panel_address (o_panel_address),
    .o_run_last      (o_run_last),
    .o_shadow_write  (o_shadow_write)
);

>>> test/palette_pixel_upscaler_tb.sv
// ----------------------------------------------------------------------------
// palette_pixel_upscaler testbench
// drives logical pixels through the upscaler under random valid and stall
// gaps, predicts every clipped panel write of each run in the bench and
// checks each output beat field by field against the oldest prediction
// ----------------------------------------------------------------------------
module tb;
    import ppu_pkg::*;

    localparam int IDLE_PCT      = 11;
    localparam int SETTLE_CYCLES = 16;
    localparam int STUCK_LIMIT   = 2000;

    // 16 entry BGR565 palette, entry 0 in the low bits
    localparam logic [16*RGB_W-1:0] BGR565_LUT = {
        16'hFFFF, 16'h055E, 16'hA81F, 16'h001F, 16'hAEB0, 16'h06B0, 16'hAC10, 16'h8410,
        16'hBDD7, 16'h0554, 16'hA815, 16'h0015, 16'hAAA0, 16'h02A0, 16'hA800, 16'h0000
    };

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [COLOR_W-1:0]        color;
    } pixel_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [RGB_W-1:0]   rgb;
        logic               last;
        logic               shadow_we;
        logic [SIDX_W-1:0]  shadow_idx;
        logic [COLOR_W-1:0] shadow_color;
    } panel_beat_t;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]     i_cfg_data = '0;
    logic                      i_valid = 1'b0;
    logic                      o_stall;
    logic signed [COORD_W-1:0] i_pixel_x = '0;
    logic signed [COORD_W-1:0] i_pixel_y = '0;
    logic [COLOR_W-1:0]        i_color_index = '0;
    logic                      o_valid;
    logic                      i_stall = 1'b0;
    logic [ADDR_W-1:0]         o_panel_address;
    logic [RGB_W-1:0]          o_panel_color;
    logic                      o_run_last;
    logic                      o_shadow_write;
    logic [SIDX_W-1:0]         o_shadow_index;
    logic [COLOR_W-1:0]        o_shadow_color;

    // bench copy of the register file
    logic [SCALE_W-1:0] cfg_scale = SCALE_RST;
    logic [OFFS_W-1:0]  cfg_offset_x = OFFSET_X_RST;
    logic [OFFS_W-1:0]  cfg_offset_y = OFFSET_Y_RST;

    pixel_t      pix_q[$];
    panel_beat_t beat_q[$];
    int          mismatches = 0;
    int          stuck_cycles = 0;
    logic        pix_beat = 1'b0;
    logic        no_idle = 1'b0;

    palette_pixel_upscaler_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_pixel_x       (i_pixel_x),
        .i_pixel_y       (i_pixel_y),
        .i_color_index   (i_color_index),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_panel_address (o_panel_address),
        .o_panel_color   (o_panel_color),
        .o_run_last      (o_run_last),
        .o_shadow_write  (o_shadow_write),
        .o_shadow_index  (o_shadow_index),
        .o_shadow_color  (o_shadow_color)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // zero scale acts as one, anything above the maximum saturates
    function automatic int eff_scale();
        int s;
        s = cfg_scale;
        if (s < 1) s = 1;
        if (s > MAX_SCALE) s = MAX_SCALE;
        return s;
    endfunction

    // queue the surviving panel writes of one pixel's run
    function automatic void predict_run(pixel_t p);
        int          px;
        int          py;
        int          s;
        int          row;
        int          col;
        logic [RGB_W-1:0] rgb;
        panel_beat_t held;
        logic        have_held;
        px = $signed(p.x);
        py = $signed(p.y);
        if (px < 0 || px >= SRC_WIDTH || py < 0 || py >= SRC_HEIGHT) return;
        s = eff_scale();
        rgb = BGR565_LUT[p.color[3:0]*RGB_W +: RGB_W];
        held = '0;
        have_held = 1'b0;
        for (int r = 0; r < s; r++) begin
            for (int c = 0; c < s; c++) begin
                row = int'(cfg_offset_y) + py * s + r;
                col = int'(cfg_offset_x) + px * s + c;
                if (row >= PANEL_HEIGHT || col >= PANEL_WIDTH) continue;
                // hold one beat back so the final survivor can be marked last
                if (have_held) beat_q.push_back(held);
                held.addr         = ADDR_W'(row * PANEL_WIDTH + col);
                held.rgb          = rgb;
                held.last         = 1'b0;
                held.shadow_we    = !have_held;
                held.shadow_idx   = SIDX_W'(py * SRC_WIDTH + px);
                held.shadow_color = p.color;
                have_held = 1'b1;
            end
        end
        if (have_held) begin
            held.last = 1'b1;
            beat_q.push_back(held);
        end
    endfunction

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // input driver, pixels change on the falling edge
    always @(negedge i_clk) begin : driver
        pixel_t p;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || pix_beat) begin
            if (pix_q.size() != 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
                p = pix_q.pop_front();
                i_pixel_x     <= p.x;
                i_pixel_y     <= p.y;
                i_color_index <= p.color;
                i_valid       <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
        i_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // output monitor and predictor hook, sampled on the rising edge
    always @(posedge i_clk) begin : monitor
        panel_beat_t want;
        if (!i_rst_n) begin
            pix_beat     <= 1'b0;
            stuck_cycles <= 0;
        end else begin
            pix_beat <= i_valid && !o_stall;
            if (o_valid && !i_stall) begin
                if (beat_q.size() == 0) begin
                    $error("panel beat with nothing pending: address 0x%0h", o_panel_address);
                    mismatches++;
                end else begin
                    want = beat_q.pop_front();
                    check_field("panel_address", want.addr, o_panel_address);
                    check_field("panel_color", want.rgb, o_panel_color);
                    check_field("run_last", want.last, o_run_last);
                    check_field("shadow_write", want.shadow_we, o_shadow_write);
                    check_field("shadow_index", want.shadow_idx, o_shadow_index);
                    check_field("shadow_color", want.shadow_color, o_shadow_color);
                end
            end
            if (i_valid && !o_stall)
                predict_run(pixel_t'{i_pixel_x, i_pixel_y, i_color_index});
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
        end
    end

    // watchdog on cycles with neither an accepted pixel nor a taken beat
    always @(posedge i_clk) begin
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            CFG_SCALE:    cfg_scale = data[SCALE_W-1:0];
            CFG_OFFSET_X: cfg_offset_x = data[OFFS_W-1:0];
            CFG_OFFSET_Y: cfg_offset_y = data[OFFS_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic add_pixel(int x, int y, logic [COLOR_W-1:0] color);
        pixel_t p;
        p.x     = COORD_W'(x);
        p.y     = COORD_W'(y);
        p.color = color;
        pix_q.push_back(p);
    endtask

    // mostly pixels whose run lands on the panel, some anywhere, some noise
    task automatic add_random_pixels(int count);
        int     s;
        int     lim_x;
        int     lim_y;
        int     kind;
        pixel_t p;
        s = eff_scale();
        lim_x = (cfg_offset_x < PANEL_WIDTH) ?
                (PANEL_WIDTH - int'(cfg_offset_x) + s - 1) / s : SRC_WIDTH;
        lim_y = (cfg_offset_y < PANEL_HEIGHT) ?
                (PANEL_HEIGHT - int'(cfg_offset_y) + s - 1) / s : SRC_HEIGHT;
        if (lim_x > SRC_WIDTH) lim_x = SRC_WIDTH;
        if (lim_y > SRC_HEIGHT) lim_y = SRC_HEIGHT;
        repeat (count) begin
            kind    = $urandom_range(0, 99);
            p.color = COLOR_W'($urandom_range(0, 255));
            if (kind < 15) begin
                p.x = COORD_W'($urandom_range(0, 2047));
                p.y = COORD_W'($urandom_range(0, 2047));
            end else if (kind < 40) begin
                p.x = COORD_W'($urandom_range(0, SRC_WIDTH - 1));
                p.y = COORD_W'($urandom_range(0, SRC_HEIGHT - 1));
            end else begin
                p.x = COORD_W'($urandom_range(0, lim_x));
                p.y = COORD_W'($urandom_range(0, lim_y));
            end
            pix_q.push_back(p);
        end
    endtask

    // wait until every run has come out, then let a clipped run finish
    task automatic wait_drained();
        while (pix_q.size() != 0 || i_valid || beat_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(logic [CFG_DATA_W-1:0] scale_data, int ox, int oy,
                             int count, logic quiet);
        wait_drained();
        cfg_write(CFG_SCALE, scale_data);
        cfg_write(CFG_OFFSET_X, CFG_DATA_W'(ox));
        cfg_write(CFG_OFFSET_Y, CFG_DATA_W'(oy));
        @(posedge i_clk);
        no_idle = quiet;
        add_random_pixels(count);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed pixels at reset settings: corners, frame edges, far coords
        add_pixel(0, 0, 8'h00);
        add_pixel(SRC_WIDTH - 1, SRC_HEIGHT - 1, 8'hFF);
        add_pixel(SRC_WIDTH, 0, 8'h01);
        add_pixel(0, SRC_HEIGHT, 8'h02);
        add_pixel(-1, 5, 8'h03);
        add_pixel(5, -1, 8'h04);
        add_pixel(-1024, -1024, 8'h5A);
        add_pixel(1023, 1023, 8'hA5);
        // every palette entry, with the high nibble varied
        for (int n = 0; n < 16; n++)
            add_pixel(n * 21, n * 13, {4'(15 - n), 4'(n)});

        run_phase(10'd1, 0, 0, 24, 1'b0);
        run_phase(10'd8, 0, 0, 24, 1'b0);
        // runs clipped at the panel's right and bottom edges
        run_phase(10'd3, 600, 450, 24, 1'b0);
        // zero scale with upper data bits set, every run off the panel
        run_phase(10'h3F0, 1023, 1023, 20, 1'b0);
        // saturated scale with both sides streaming
        run_phase(10'd15, 5, 7, 24, 1'b1);
        run_phase(10'd4, 100, 60, 24, 1'b0);
        run_phase(10'h209, 17, 3, 24, 1'b0);

        wait_drained();
        if (mismatches == 0 && beat_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
